### src/sbox_pkg.sv
// Shared types and codes for the sorted box overlap query block.
// Used by src/sorted_box_overlap_query.sv; depends on nothing else.
`timescale 1ns / 1ps

package sbox_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_RESORT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_MATCH    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
    logic [15:0]        object_tag;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] hit_tag;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DONE,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_PLACE,
    S_SUF_WR,
    S_Q_EVAL,
    S_FINISH
  } state_t;

endpackage

### src/sorted_box_overlap_query.sv
// Sort-and-sweep box table with append, resort and overlap query commands.
// Depends on src/sbox_pkg.sv for request, response and state types.
`timescale 1ns / 1ps

// One request is handled at a time; req_stall is high until its results are
// queued. A query makes one memory read per entry visited and waits while
// rsp_stall holds back a result. A resort runs a stable insertion sort through
// the one read port and one write port of the entry memory: it fetches each key
// and then its left neighbor, shifts each larger entry right, places the key,
// then rebuilds the suffix minima from the last entry back. The entry memory
// needs no clearing after reset; only entries below the fill count are ever used.
module sorted_box_overlap_query #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sbox_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sbox_pkg::rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic [CB-1:0] lx;
    logic [CB-1:0] ly;
    logic [CB-1:0] lz;
    logic [CB-1:0] hx;
    logic [CB-1:0] hy;
    logic [CB-1:0] hz;
    logic [15:0]   tag;
    logic [CB-1:0] sm;
  } entry_t;

  // Keep the low bits and flip the sign so unsigned compares give signed order.
  function automatic logic [CB-1:0] bias(input logic [31:0] v);
    logic [CB+31:0] ext;
    logic [CB-1:0]  r;
    ext = {{CB{1'b0}}, v};
    r = ext[CB-1:0];
    r[CB-1] = ~r[CB-1];
    return r;
  endfunction

  sbox_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] idx, idx_next;
  logic [IW-1:0] sj, sj_next;
  entry_t        key, key_next;
  entry_t        qb, qb_next;
  logic [CB-1:0] run, run_next;
  logic          first, first_next;
  logic          skip, skip_next;
  logic          pend, pend_next;
  logic [15:0]   ptag, ptag_next;
  sbox_pkg::status_t stat, stat_next;
  logic          rsp_valid_next;
  sbox_pkg::rsp_t rsp_next;

  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_ra;
  entry_t        mem_wd;
  entry_t        rd_q;
  entry_t        mem [CAPACITY];

  logic          out_free;
  logic          req_fire;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] si_p1;
  logic          hit;
  logic [CB-1:0] min_v;

  assign out_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != sbox_pkg::S_IDLE);
  assign req_fire = req_valid && !req_stall;
  assign count_m1 = count - CW'(1);
  assign idx_p1 = CW'(idx) + CW'(1);
  assign si_p1 = idx_p1;
  assign hit = (rd_q.ly < qb.hy) && (rd_q.hy > qb.ly) &&
               (rd_q.lz < qb.hz) && (rd_q.hz > qb.lz);
  assign min_v = first ? rd_q.lx : ((rd_q.lx < run) ? rd_q.lx : run);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbox_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
      pend      <= pend_next;
    end
    idx   <= idx_next;
    sj    <= sj_next;
    key   <= key_next;
    qb    <= qb_next;
    run   <= run_next;
    first <= first_next;
    skip  <= skip_next;
    ptag  <= ptag_next;
    stat  <= stat_next;
    rsp   <= rsp_next;
  end

  // Command sequencer: next state, memory accesses and result loading.
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    sj_next        = sj;
    key_next       = key;
    qb_next        = qb;
    run_next       = run;
    first_next     = first;
    skip_next      = skip;
    pend_next      = pend;
    ptag_next      = ptag;
    stat_next      = stat;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    mem_we         = 1'b0;
    mem_wa         = sj;
    mem_wd         = key;
    mem_ra         = idx;

    case (state)
      sbox_pkg::S_IDLE: begin
        qb_next.lx  = bias(req.lo_x);
        qb_next.ly  = bias(req.lo_y);
        qb_next.lz  = bias(req.lo_z);
        qb_next.hx  = bias(req.hi_x);
        qb_next.hy  = bias(req.hi_y);
        qb_next.hz  = bias(req.hi_z);
        qb_next.tag = req.object_tag;
        qb_next.sm  = bias(req.lo_x);
        mem_ra      = '0;
        idx_next    = '0;
        if (req_fire) begin
          stat_next = sbox_pkg::ST_DONE;
          case (req.cmd)
            sbox_pkg::CMD_CLEAR: begin
              count_next = '0;
              state_next = sbox_pkg::S_DONE;
            end
            sbox_pkg::CMD_APPEND: begin
              state_next = sbox_pkg::S_DONE;
              if (count >= CW'(CAPACITY)) begin
                stat_next = sbox_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wa     = count[IW-1:0];
                mem_wd     = qb_next;
                count_next = count + CW'(1);
              end
            end
            sbox_pkg::CMD_RESORT: begin
              if (count > CW'(1)) begin
                idx_next   = IW'(1);
                mem_ra     = IW'(1);
                state_next = sbox_pkg::S_SORT_KEY;
              end else if (count == CW'(1)) begin
                first_next = 1'b1;
                state_next = sbox_pkg::S_SUF_WR;
              end else begin
                state_next = sbox_pkg::S_DONE;
              end
            end
            default: begin
              pend_next = 1'b0;
              skip_next = 1'b1;
              if (count == '0) begin
                state_next = sbox_pkg::S_FINISH;
              end else begin
                state_next = sbox_pkg::S_Q_EVAL;
              end
            end
          endcase
        end
      end

      // Key for this insertion step has arrived; fetch its left neighbor.
      sbox_pkg::S_SORT_KEY: begin
        key_next   = rd_q;
        sj_next    = idx;
        mem_ra     = idx - IW'(1);
        state_next = sbox_pkg::S_SORT_CMP;
      end

      // Shift the neighbor right while it is strictly above the key.
      sbox_pkg::S_SORT_CMP: begin
        if (rd_q.hx > key.hx) begin
          mem_we  = 1'b1;
          mem_wa  = sj;
          mem_wd  = rd_q;
          sj_next = sj - IW'(1);
          if (sj == IW'(1)) begin
            state_next = sbox_pkg::S_SORT_PLACE;
          end else begin
            mem_ra = sj - IW'(2);
          end
        end else begin
          state_next = sbox_pkg::S_SORT_PLACE;
          mem_we     = 1'b1;
          idx_next   = idx + IW'(1);
          mem_ra     = idx + IW'(1);
          if (si_p1 == count) begin
            mem_ra     = count_m1[IW-1:0];
            idx_next   = count_m1[IW-1:0];
            first_next = 1'b1;
            state_next = sbox_pkg::S_SUF_WR;
          end else begin
            state_next = sbox_pkg::S_SORT_KEY;
          end
        end
      end

      // Key goes to the front of the sorted run.
      sbox_pkg::S_SORT_PLACE: begin
        mem_we   = 1'b1;
        idx_next = idx + IW'(1);
        mem_ra   = idx + IW'(1);
        if (si_p1 == count) begin
          mem_ra     = count_m1[IW-1:0];
          idx_next   = count_m1[IW-1:0];
          first_next = 1'b1;
          state_next = sbox_pkg::S_SUF_WR;
        end else begin
          state_next = sbox_pkg::S_SORT_KEY;
        end
      end

      // Suffix minima from the last entry back to the first.
      sbox_pkg::S_SUF_WR: begin
        if (first && (idx != count_m1[IW-1:0])) begin
          // Last entry not yet fetched: its read is issued here before the first write.
          mem_ra = count_m1[IW-1:0];
          idx_next = count_m1[IW-1:0];
        end else begin
          mem_we     = 1'b1;
          mem_wa     = idx;
          mem_wd     = rd_q;
          mem_wd.sm  = min_v;
          run_next   = min_v;
          first_next = 1'b0;
          if (idx == '0) begin
            state_next = sbox_pkg::S_DONE;
          end else begin
            idx_next = idx - IW'(1);
            mem_ra   = idx - IW'(1);
          end
        end
      end

      // Query: skip by upper x, then sweep while the suffix minimum is low.
      sbox_pkg::S_Q_EVAL: begin
        if (skip && (rd_q.hx < qb.lx)) begin
          idx_next = idx + IW'(1);
          mem_ra   = idx + IW'(1);
          if (idx_p1 == count) begin
            state_next = sbox_pkg::S_FINISH;
          end
        end else if (!(rd_q.sm < qb.hx)) begin
          state_next = sbox_pkg::S_FINISH;
        end else if (hit && pend && !out_free) begin
          mem_ra = idx;
        end else begin
          skip_next = 1'b0;
          if (hit) begin
            if (pend) begin
              rsp_valid_next   = 1'b1;
              rsp_next.status  = sbox_pkg::ST_MATCH;
              rsp_next.hit_tag = ptag;
              rsp_next.last    = 1'b0;
            end
            pend_next = 1'b1;
            ptag_next = rd_q.tag;
          end
          idx_next = idx + IW'(1);
          mem_ra   = idx + IW'(1);
          if (idx_p1 == count) begin
            state_next = sbox_pkg::S_FINISH;
          end
        end
      end

      // Final query result: the held hit, or a no-match marker.
      sbox_pkg::S_FINISH: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next.last  = 1'b1;
          if (pend) begin
            rsp_next.status  = sbox_pkg::ST_MATCH;
            rsp_next.hit_tag = ptag;
          end else begin
            rsp_next.status  = sbox_pkg::ST_NO_MATCH;
            rsp_next.hit_tag = '0;
          end
          pend_next  = 1'b0;
          state_next = sbox_pkg::S_IDLE;
        end
      end

      // Single result of clear, append and resort.
      sbox_pkg::S_DONE: begin
        if (out_free) begin
          rsp_valid_next   = 1'b1;
          rsp_next.status  = stat;
          rsp_next.hit_tag = '0;
          rsp_next.last    = 1'b1;
          state_next       = sbox_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sbox_pkg::S_IDLE;
      end
    endcase
  end

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A non-final result means the query is still running.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (state != sbox_pkg::S_IDLE))
    else $error("non-final result with block idle");

  // An append into a full table leaves the count alone.
  a_full_append: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.cmd == sbox_pkg::CMD_APPEND && count == CW'(CAPACITY))
    |=> (count == CW'(CAPACITY)))
    else $error("append into full table changed the count");

  // Query scan stays inside the filled part of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sbox_pkg::S_Q_EVAL) |-> (CW'(idx) < count))
    else $error("query scan past the last entry");

endmodule

### verif/tb_sorted_box_overlap_query.sv
// Testbench for sorted_box_overlap_query: random and directed box commands.
// Depends on src/sbox_pkg.sv and src/sorted_box_overlap_query.sv.
`timescale 1ns / 1ps

// Tracks the box table and queues the responses each accepted request causes.
class box_table_sb;
  localparam int CAP = 64;
  logic [31:0] lox[CAP], loy[CAP], loz[CAP], hix[CAP], hiy[CAP], hiz[CAP];
  logic [31:0] sufmin[CAP];
  logic [15:0] tags[CAP];
  int unsigned fill;
  sbox_pkg::rsp_t pending[$];
  int errors;

  function new();
    fill = 0;
    errors = 0;
  endfunction

  // Flip the sign bit so unsigned compares follow the signed order.
  static function logic [31:0] biased(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  function void add_expected(sbox_pkg::status_t st, logic [15:0] tg, logic lst);
    sbox_pkg::rsp_t r;
    r.status = st;
    r.hit_tag = tg;
    r.last = lst;
    pending.insert(pending.size(), r);
  endfunction

  // Stable insertion sort on upper x, then rebuild the suffix minima.
  function void resort_table();
    logic [31:0] a, b, c, d, e, f, s;
    logic [15:0] t;
    int j;
    for (int i = 1; i < fill; i++) begin
      a = lox[i]; b = loy[i]; c = loz[i]; d = hix[i]; e = hiy[i]; f = hiz[i];
      t = tags[i]; s = sufmin[i];
      j = i;
      while (j > 0 && hix[j-1] > d) begin
        lox[j] = lox[j-1]; loy[j] = loy[j-1]; loz[j] = loz[j-1];
        hix[j] = hix[j-1]; hiy[j] = hiy[j-1]; hiz[j] = hiz[j-1];
        tags[j] = tags[j-1]; sufmin[j] = sufmin[j-1];
        j--;
      end
      lox[j] = a; loy[j] = b; loz[j] = c; hix[j] = d; hiy[j] = e; hiz[j] = f;
      tags[j] = t; sufmin[j] = s;
    end
    if (fill > 0) begin
      sufmin[fill-1] = lox[fill-1];
      for (int i = fill - 1; i > 0; i--)
        sufmin[i-1] = (lox[i-1] < sufmin[i]) ? lox[i-1] : sufmin[i];
    end
  endfunction

  function void note_request(sbox_pkg::req_t q);
    logic [31:0] qlx, qly, qlz, qhx, qhy, qhz;
    int i, hits;
    qlx = biased(q.lo_x); qly = biased(q.lo_y); qlz = biased(q.lo_z);
    qhx = biased(q.hi_x); qhy = biased(q.hi_y); qhz = biased(q.hi_z);
    case (q.cmd)
      sbox_pkg::CMD_CLEAR: begin
        fill = 0;
        add_expected(sbox_pkg::ST_DONE, 16'd0, 1'b1);
      end
      sbox_pkg::CMD_APPEND: begin
        if (fill >= CAP) begin
          add_expected(sbox_pkg::ST_FULL, 16'd0, 1'b1);
        end else begin
          lox[fill] = qlx; loy[fill] = qly; loz[fill] = qlz;
          hix[fill] = qhx; hiy[fill] = qhy; hiz[fill] = qhz;
          tags[fill] = q.object_tag;
          sufmin[fill] = qlx;
          fill++;
          add_expected(sbox_pkg::ST_DONE, 16'd0, 1'b1);
        end
      end
      sbox_pkg::CMD_RESORT: begin
        resort_table();
        add_expected(sbox_pkg::ST_DONE, 16'd0, 1'b1);
      end
      default: begin
        i = 0;
        hits = 0;
        while (i < fill && hix[i] < qlx) i++;
        while (i < fill && sufmin[i] < qhx) begin
          if (loy[i] < qhy && hiy[i] > qly && loz[i] < qhz && hiz[i] > qlz) begin
            add_expected(sbox_pkg::ST_MATCH, tags[i], 1'b0);
            hits++;
          end
          i++;
        end
        if (hits == 0) add_expected(sbox_pkg::ST_NO_MATCH, 16'd0, 1'b1);
        else pending[$].last = 1'b1;
      end
    endcase
  endfunction

  function void check_response(sbox_pkg::rsp_t r);
    sbox_pkg::rsp_t x;
    if (pending.size() == 0) begin
      $display("%0t: unexpected response %h", $time, r);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (r.status !== x.status) begin
      $display("%0t: status expected %0d actual %0d", $time, x.status, r.status);
      errors++;
    end
    if (r.hit_tag !== x.hit_tag) begin
      $display("%0t: hit_tag expected %h actual %h", $time, x.hit_tag, r.hit_tag);
      errors++;
    end
    if (r.last !== x.last) begin
      $display("%0t: last expected %0d actual %0d", $time, x.last, r.last);
      errors++;
    end
  endfunction
endclass

module tb_sorted_box_overlap_query;

  localparam int CYCLE_LIMIT = 10_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  sbox_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  sbox_pkg::rsp_t rsp;

  box_table_sb sb = new();
  int unsigned cycles = 0;
  int burst_left = 0;
  bit stall_free = 1'b0;

  sorted_box_overlap_query u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #2 clk = ~clk;

  // Check responses and run the cycle guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_box_overlap_query: done, errors");
      $finish;
    end
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Receiver stall pattern: quiet stretches alternate with random stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
    rsp_stall <= stall_free ? 1'b0 : ($urandom_range(0, 3) == 0);
  end

  // Drive one request, holding it until accepted; gaps come between bursts.
  // Valid stays high after acceptance only when the next request follows in
  // the same step, so it is dropped at the start of a gap or a drain.
  task automatic send(sbox_pkg::req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(q);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  function automatic sbox_pkg::req_t make_box(sbox_pkg::cmd_t c, logic [31:0] lx,
                                              logic [31:0] ly, logic [31:0] lz,
                                              logic [31:0] hx, logic [31:0] hy,
                                              logic [31:0] hz);
    sbox_pkg::req_t q;
    q.cmd = c;
    q.lo_x = lx; q.lo_y = ly; q.lo_z = lz;
    q.hi_x = hx; q.hi_y = hy; q.hi_z = hz;
    q.object_tag = $urandom();
    return q;
  endfunction

  // Small boxes around the origin so queries find overlaps often.
  function automatic sbox_pkg::req_t rand_small(sbox_pkg::cmd_t c);
    int cx, cy, cz;
    cx = $urandom_range(0, 200) - 100;
    cy = $urandom_range(0, 200) - 100;
    cz = $urandom_range(0, 200) - 100;
    return make_box(c, cx, cy, cz, cx + $urandom_range(0, 60),
                    cy + $urandom_range(0, 80), cz + $urandom_range(0, 80));
  endfunction

  function automatic sbox_pkg::req_t rand_any(sbox_pkg::cmd_t c);
    return make_box(c, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
  endfunction

  // Stop sending and wait until every expected response has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    sbox_pkg::req_t q;
    int fill_target;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: query and resort on an empty table.
    send(rand_small(sbox_pkg::CMD_QUERY));
    send(rand_small(sbox_pkg::CMD_RESORT));
    // One entry, resorted, then extreme boxes.
    send(make_box(sbox_pkg::CMD_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send(rand_small(sbox_pkg::CMD_RESORT));
    send(make_box(sbox_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    // Equal upper x keeps insertion order; an inverted box too.
    send(make_box(sbox_pkg::CMD_APPEND, 0, 0, 0, 10, 10, 10));
    send(make_box(sbox_pkg::CMD_APPEND, -5, 0, 0, 10, 10, 10));
    send(make_box(sbox_pkg::CMD_APPEND, 20, 20, 20, -20, -20, -20));
    send(make_box(sbox_pkg::CMD_QUERY, 1, 1, 1, 5, 5, 5));
    send(rand_small(sbox_pkg::CMD_RESORT));
    send(make_box(sbox_pkg::CMD_QUERY, 1, 1, 1, 5, 5, 5));
    send(make_box(sbox_pkg::CMD_QUERY, 10, 10, 10, 10, 10, 10));
    send(make_box(sbox_pkg::CMD_QUERY, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 1, 1));
    // Fill to capacity and overflow.
    repeat (62) send(rand_small(sbox_pkg::CMD_APPEND));
    send(rand_any(sbox_pkg::CMD_APPEND));
    send(rand_small(sbox_pkg::CMD_RESORT));
    send(rand_small(sbox_pkg::CMD_QUERY));
    send(rand_small(sbox_pkg::CMD_CLEAR));
    // Hold off until every response is back.
    drain();

    // Random: mostly build, resort, query sequences; some noise.
    for (int n = 0; n < 270; ) begin
      if ($urandom_range(0, 9) == 0) fill_target = 64 + $urandom_range(0, 2);
      else fill_target = $urandom_range(0, 12);
      send(rand_any(sbox_pkg::CMD_CLEAR)); n++;
      for (int k = 0; k < fill_target; k++) begin
        send($urandom_range(0, 4) == 0 ? rand_any(sbox_pkg::CMD_APPEND)
                                       : rand_small(sbox_pkg::CMD_APPEND));
        n++;
      end
      if ($urandom_range(0, 4) != 0) begin
        send(rand_any(sbox_pkg::CMD_RESORT)); n++;
      end
      repeat ($urandom_range(1, 6)) begin
        q = $urandom_range(0, 3) == 0 ? rand_any(sbox_pkg::CMD_QUERY)
                                      : rand_small(sbox_pkg::CMD_QUERY);
        send(q); n++;
        if ($urandom_range(0, 7) == 0) begin
          send(rand_small(sbox_pkg::cmd_t'($urandom_range(1, 2)))); n++;
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_sorted_box_overlap_query: done, clean");
    else
      $display("tb_sorted_box_overlap_query: done, errors");
    $finish;
  end
endmodule

### sim.f
src/sbox_pkg.sv
src/sorted_box_overlap_query.sv
verif/tb_sorted_box_overlap_query.sv
